// ===== design/assert_macros.svh =====
// Assertion macros used by the frame table datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is held.
`define LRUPR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define LRUPR_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/lrupr_pkg.sv =====
// Types and constants shared by the frame table controller, datapath and top level.
package lrupr_pkg;

    localparam int PAGE_W  = 16;
    localparam int FRAME_W = 4;
    localparam int COUNT_W = 32;
    localparam int CFG_W   = 5;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd3;

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic              end_of_string;
    } in_req_t;

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame;
        logic               evicted_valid;
        logic [PAGE_W-1:0]  evicted_page;
        logic [COUNT_W-1:0] fault_count;
    } out_req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic issue;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic last_issue;
        logic out_free;
    } status_t;

endpackage

// ===== design/lrupr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module lrupr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/lrupr_ctrl.sv =====
// Sequencer that steps each request through scan, finish and commit.
module lrupr_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  lrupr_pkg::status_t st,
    output lrupr_pkg::cmd_t    cmd
);

    import lrupr_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.issue = 1'b1;
                if (st.last_issue) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // The last page read is judged in this cycle.
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (st.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/lrupr_datapath.sv =====
// Frame table datapath: page RAM, valid bits, recency ranks, scan unit and result register.
`include "assert_macros.svh"

module lrupr_datapath #(
    parameter int FRAMES_MAX = 16,
    parameter int PAGE_BITS  = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [lrupr_pkg::CFG_W-1:0]   cfg_wr_data,
    input  lrupr_pkg::in_req_t            s_req,
    input  lrupr_pkg::cmd_t               cmd,
    output lrupr_pkg::status_t            st,
    output logic                          m_valid,
    input  logic                          m_ready,
    output lrupr_pkg::out_req_t           m_req
);

    import lrupr_pkg::*;

    localparam int FIDX_W  = (FRAMES_MAX > 1) ? $clog2(FRAMES_MAX) : 1;
    localparam int RANK_W  = FIDX_W;
    localparam int MCNT_W  = $clog2(FRAMES_MAX + 1);
    localparam int CMP_W   = (MCNT_W > CFG_W) ? MCNT_W : CFG_W;
    localparam logic [CMP_W-1:0]  FRAMES_CMP = CMP_W'(FRAMES_MAX);
    localparam logic [FIDX_W-1:0] LAST_FRAME = FIDX_W'(FRAMES_MAX - 1);

    // Configuration and per-request registers.
    logic [CFG_W-1:0]     cfg_reg;
    logic [PAGE_BITS-1:0] page_reg;
    logic                 eos_reg;
    logic [FIDX_W-1:0]    m_last_reg;
    logic [FIDX_W-1:0]    m_last_next;

    // Scan unit.
    logic [FIDX_W-1:0]    scan_idx_reg;
    logic                 rd_valid_reg;
    logic [FIDX_W-1:0]    rd_idx_reg;
    logic [PAGE_BITS-1:0] rd_page;
    logic                 rd_frame_valid;
    logic [RANK_W-1:0]    rd_rank;

    logic                 hit_found_reg;
    logic [FIDX_W-1:0]    hit_idx_reg;
    logic [RANK_W-1:0]    hit_rank_reg;
    logic                 empty_found_reg;
    logic [FIDX_W-1:0]    empty_idx_reg;
    logic [RANK_W-1:0]    max_rank_reg;
    logic [FIDX_W-1:0]    max_idx_reg;
    logic [PAGE_BITS-1:0] max_page_reg;

    // Frame state.
    logic [FRAMES_MAX-1:0] valid_reg;
    logic [FRAMES_MAX-1:0] valid_next;
    logic [RANK_W-1:0]     rank_reg  [FRAMES_MAX];
    logic [RANK_W-1:0]     rank_next [FRAMES_MAX];
    logic [COUNT_W-1:0]    fault_reg;
    logic [COUNT_W-1:0]    fault_next;

    // Commit decision.
    logic [FIDX_W-1:0]  sel_frame;
    logic               evict;
    logic               age_all;
    logic [RANK_W-1:0]  old_rank;
    logic [COUNT_W-1:0] fault_new;

    // Result register.
    logic     out_valid_reg;
    out_req_t out_reg;

    // Configuration register; write it only while the block is idle (the block itself does not enforce this).
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_wr_en) begin
            cfg_reg <= cfg_wr_data;
        end
    end

    // Last frame index in use: a count of zero acts as one, and the count is capped.
    always_comb begin
        if (CMP_W'(cfg_reg) == '0) begin
            m_last_next = '0;
        end else if (CMP_W'(cfg_reg) > FRAMES_CMP) begin
            m_last_next = LAST_FRAME;
        end else begin
            m_last_next = FIDX_W'(CMP_W'(cfg_reg) - CMP_W'(1));
        end
    end

    // Request capture and scan address counter.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            page_reg   <= PAGE_BITS'(s_req.page);
            eos_reg    <= s_req.end_of_string;
            m_last_reg <= m_last_next;
        end
        if (cmd.load) begin
            scan_idx_reg <= '0;
        end else if (cmd.issue) begin
            scan_idx_reg <= scan_idx_reg + FIDX_W'(1);
        end
        rd_idx_reg <= scan_idx_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= cmd.issue;
        end
    end

    assign st.last_issue = (scan_idx_reg == m_last_reg);
    assign st.out_free   = !out_valid_reg || m_ready;

    // Page store; only misses write it.
    lrupr_ram #(
        .WIDTH (PAGE_BITS),
        .DEPTH (FRAMES_MAX)
    ) u_page_ram (
        .aclk    (aclk),
        .wr_en   (cmd.commit && !hit_found_reg),
        .wr_addr (sel_frame),
        .wr_data (page_reg),
        .rd_addr (scan_idx_reg),
        .rd_data (rd_page)
    );

    assign rd_frame_valid = valid_reg[rd_idx_reg];
    assign rd_rank        = rank_reg[rd_idx_reg];

    // Scan results: first match, first empty frame, first oldest frame.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_found_reg   <= 1'b0;
            empty_found_reg <= 1'b0;
        end else if (cmd.load) begin
            hit_found_reg   <= 1'b0;
            empty_found_reg <= 1'b0;
        end else if (rd_valid_reg) begin
            if (!hit_found_reg && rd_frame_valid && (rd_page == page_reg)) begin
                hit_found_reg <= 1'b1;
            end
            if (!empty_found_reg && !rd_frame_valid) begin
                empty_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_valid_reg) begin
            if (!hit_found_reg && rd_frame_valid && (rd_page == page_reg)) begin
                hit_idx_reg  <= rd_idx_reg;
                hit_rank_reg <= rd_rank;
            end
            if (!empty_found_reg && !rd_frame_valid) begin
                empty_idx_reg <= rd_idx_reg;
            end
            // Frame zero seeds the search; later frames replace it only when strictly older.
            if ((rd_idx_reg == '0) || (rd_rank > max_rank_reg)) begin
                max_rank_reg <= rd_rank;
                max_idx_reg  <= rd_idx_reg;
                max_page_reg <= rd_page;
            end
        end
    end

    // Frame chosen for this request and the rank threshold for aging.
    always_comb begin
        evict   = !hit_found_reg && !empty_found_reg;
        age_all = !hit_found_reg && empty_found_reg;
        if (hit_found_reg) begin
            sel_frame = hit_idx_reg;
            old_rank  = hit_rank_reg;
        end else if (empty_found_reg) begin
            sel_frame = empty_idx_reg;
            old_rank  = '0;
        end else begin
            sel_frame = max_idx_reg;
            old_rank  = max_rank_reg;
        end
        if (hit_found_reg || (fault_reg == '1)) begin
            fault_new = fault_reg;
        end else begin
            fault_new = fault_reg + COUNT_W'(1);
        end
    end

    // Promotion of the chosen frame; an end of string clears the table instead.
    always_comb begin
        for (int j = 0; j < FRAMES_MAX; j++) begin
            valid_next[j] = valid_reg[j];
            rank_next[j]  = rank_reg[j];
            if (cmd.commit) begin
                if (eos_reg) begin
                    valid_next[j] = 1'b0;
                    rank_next[j]  = '0;
                end else if (FIDX_W'(j) == sel_frame) begin
                    valid_next[j] = 1'b1;
                    rank_next[j]  = '0;
                end else if (valid_reg[j] && (age_all || (rank_reg[j] < old_rank))) begin
                    rank_next[j] = rank_reg[j] + RANK_W'(1);
                end
            end
        end
        fault_next = fault_reg;
        if (cmd.commit) begin
            fault_next = eos_reg ? '0 : fault_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            fault_reg <= '0;
            for (int j = 0; j < FRAMES_MAX; j++) begin
                rank_reg[j] <= '0;
            end
        end else begin
            valid_reg <= valid_next;
            fault_reg <= fault_next;
            for (int j = 0; j < FRAMES_MAX; j++) begin
                rank_reg[j] <= rank_next[j];
            end
        end
    end

    // Result register, loaded at commit and freed when taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_reg.hit           <= hit_found_reg;
            out_reg.frame         <= FRAME_W'(sel_frame);
            out_reg.evicted_valid <= evict;
            out_reg.evicted_page  <= evict ? PAGE_W'(max_page_reg) : '0;
            out_reg.fault_count   <= fault_new;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_req   = out_reg;

    // A commit never overwrites a result that is still waiting.
    `LRUPR_ASSERT(a_commit_slot_free, aclk, aresetn, cmd.commit |-> (!out_valid_reg || m_ready), "commit while result pending")
    // The chosen frame always lies among the frames in use.
    `LRUPR_ASSERT(a_frame_in_use, aclk, aresetn, cmd.commit |-> (sel_frame <= m_last_reg), "chosen frame outside frames in use")
    // Outside an end of string, the chosen frame is valid after commit.
    `LRUPR_ASSERT(a_frame_valid_after, aclk, aresetn, (cmd.commit && !eos_reg) |=> valid_reg[$past(sel_frame)], "chosen frame not valid")
    // Outside an end of string, a hit leaves the fault count unchanged.
    `LRUPR_ASSERT(a_hit_no_fault, aclk, aresetn, (cmd.commit && hit_found_reg && !eos_reg) |=> (fault_reg == $past(fault_reg)), "fault counted on hit")

endmodule

// ===== design/lru_page_replacement_core.sv =====
// Top level of the least-recently-used page frame table.
//
//   Channel  Direction  Handshake              Contents
//   s_       in         s_valid / s_ready      one page reference request
//   m_       out        m_valid / m_ready      hit, frame, eviction, fault count
//   cfg_     in         cfg_wr_en              frames_in_use, 5 bits
//
// A request is accepted only once the previous one has committed; the scan reads
// the page of each frame in use, one page per cycle, from the page RAM and judges
// it against the valid bits and ranks.
// Reset clears valid bits, ranks, the fault count and sets frames_in_use to 3;
// the page RAM is not cleared, since unwritten frames are never valid.
// A result waits in the output register while the next request is scanned; that
// request commits once the waiting result has been taken.
module lru_page_replacement_core #(
    parameter int FRAMES_MAX = 16,
    parameter int PAGE_BITS  = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [lrupr_pkg::CFG_W-1:0] cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  lrupr_pkg::in_req_t          s_req,
    output logic                        m_valid,
    input  logic                        m_ready,
    output lrupr_pkg::out_req_t         m_req
);

    import lrupr_pkg::*;

    cmd_t    cmd;
    status_t st;

    // Sequencer.
    lrupr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    // Frame table and result register.
    lrupr_datapath #(
        .FRAMES_MAX (FRAMES_MAX),
        .PAGE_BITS  (PAGE_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_req       (s_req),
        .cmd         (cmd),
        .st          (st),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_req       (m_req)
    );

endmodule
